/* src/cpsd_pkg.sv */
// ----------------------------------------------------------------------------
// Checkpoint slot directory package
// Shared operation codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpsd_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SAVE  = 2'd1,
        OP_FIND  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    // Source of the directory read address.
    typedef enum logic [1:0] {
        RD_ANCHOR = 2'd0,
        RD_SCAN   = 2'd1,
        RD_SLOT   = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    save_wr;
        rd_sel_t rd_sel;
        logic    scan;
        logic    query_ev;
        logic    find_res;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

/* src/cpsd_ram.sv */
// ----------------------------------------------------------------------------
// Checkpoint slot directory RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module cpsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/cpsd_ctrl.sv */
// ----------------------------------------------------------------------------
// Checkpoint slot directory controller
// Sequences one operation at a time and issues commands to the datapath.
// ----------------------------------------------------------------------------
module cpsd_ctrl
    import cpsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  op_t     op,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SAVE_RD,
        S_SAVE_WR,
        S_QUERY_RD,
        S_QUERY_EV,
        S_FIND,
        S_FIND_END,
        S_FIND_RES,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_ANCHOR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (op)
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_SAVE:  state_next = S_SAVE_RD;
                        OP_FIND:  state_next = S_FIND;
                        OP_QUERY: state_next = S_QUERY_RD;
                        default:  state_next = S_CLEAR;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_RESP;
            end
            S_SAVE_RD:
            begin
                cmd.rd_sel = RD_ANCHOR;
                state_next = S_SAVE_WR;
            end
            S_SAVE_WR:
            begin
                cmd.save_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_QUERY_RD:
            begin
                cmd.rd_sel = RD_SLOT;
                state_next = S_QUERY_EV;
            end
            S_QUERY_EV:
            begin
                cmd.query_ev = 1'b1;
                state_next   = S_RESP;
            end
            S_FIND:
            begin
                cmd.rd_sel = RD_SCAN;
                cmd.scan   = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_FIND_END;
                end
            end
            S_FIND_END:
            begin
                state_next = S_FIND_RES;
            end
            S_FIND_RES:
            begin
                cmd.find_res = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/cpsd_dp.sv */
// ----------------------------------------------------------------------------
// Checkpoint slot directory datapath
// Holds the slot table, counters, the find scan and the output register.
// ----------------------------------------------------------------------------
module cpsd_dp
    import cpsd_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [31:0] step,
    input  logic [2:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  slot_index,
    output logic        found,
    output logic [31:0] slot_step,
    output logic [3:0]  used_count
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam logic [IDXW:0] SLOTS_X = (IDXW + 1)'(SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
    localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SLOTS);
    localparam logic [IDXW-1:0] IDX_ONE = IDXW'(1);

    // Captured operation.
    logic [31:0]     step_reg;
    logic [2:0]      slot_reg;

    // Directory state.
    logic [SLOTS-1:0] valid_reg;
    logic [31:0]      seq_reg;
    logic [IDXW-1:0]  ring_reg;
    logic [CNTW-1:0]  count_reg;

    // Find scan.
    logic [IDXW-1:0] scan_reg;
    logic [IDXW-1:0] cmp_idx_reg;
    logic            cmp_vld_reg;
    logic            have_reg;
    logic [IDXW-1:0] best_idx_reg;
    logic [31:0]     best_step_reg;
    logic [31:0]     best_seq_reg;

    // Result of the current operation.
    logic [IDXW-1:0] res_idx_reg;
    logic            res_found_reg;
    logic [31:0]     res_step_reg;

    // Output word.
    logic            out_valid_reg;
    logic [2:0]      slot_index_reg;
    logic            found_reg;
    logic [31:0]     slot_step_reg;
    logic [3:0]      used_count_reg;

    // Memory interface: upper half is the step, lower half the sequence.
    logic [IDXW-1:0] raddr;
    logic [63:0]     rdata;
    logic [31:0]     rd_step;
    logic [31:0]     rd_seq;
    logic            ram_we;
    logic [IDXW-1:0] save_idx;
    logic [31:0]     seq_inc;
    logic [IDXW:0]   ring_inc;
    logic            slot_in_range;
    logic            cand;

    assign rd_step = rdata[63:32];
    assign rd_seq  = rdata[31:0];
    assign ram_we  = cmd.save_wr;
    assign seq_inc = seq_reg + 32'd1;
    assign ring_inc = {1'b0, ring_reg} + (IDXW + 1)'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ANCHOR: raddr = '0;
            RD_SCAN:   raddr = scan_reg;
            RD_SLOT:   raddr = IDXW'(slot_reg);
            default:   raddr = '0;
        endcase
    end

    // A save goes to the anchor for the first save or a repeated anchor step.
    always_comb
    begin
        if (seq_reg == 32'd0 || (valid_reg[0] && rd_step == step_reg))
        begin
            save_idx = '0;
        end
        else if (ring_reg == '0)
        begin
            save_idx = IDX_ONE;
        end
        else
        begin
            save_idx = ring_reg;
        end
    end

    assign slot_in_range = (7'(slot_reg) < 7'(SLOTS));

    // The newest entry wins among equal steps.
    assign cand = valid_reg[cmp_idx_reg] && (rd_step <= step_reg) &&
                  (!have_reg || rd_step > best_step_reg ||
                   (rd_step == best_step_reg && rd_seq > best_seq_reg));

    assign status.scan_last = (scan_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || !out_stall;

    cpsd_ram #(
        .WIDTH(64),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (save_idx),
        .wdata ({step_reg, seq_inc}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            step_reg <= step;
            slot_reg <= slot;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= scan_reg;
        end
        if (cmp_vld_reg && cand)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_step_reg <= rd_step;
            best_seq_reg  <= rd_seq;
        end
        if (cmd.clear)
        begin
            res_idx_reg   <= '0;
            res_found_reg <= 1'b0;
            res_step_reg  <= '0;
        end
        if (cmd.save_wr)
        begin
            res_idx_reg   <= save_idx;
            res_found_reg <= 1'b0;
            res_step_reg  <= '0;
        end
        if (cmd.query_ev)
        begin
            res_idx_reg   <= '0;
            res_found_reg <= slot_in_range && valid_reg[IDXW'(slot_reg)];
            res_step_reg  <= (slot_in_range && valid_reg[IDXW'(slot_reg)]) ? rd_step : '0;
        end
        if (cmd.find_res)
        begin
            res_idx_reg   <= have_reg ? best_idx_reg : '0;
            res_found_reg <= have_reg;
            res_step_reg  <= '0;
        end
        if (cmd.load_out)
        begin
            slot_index_reg <= 3'(res_idx_reg);
            found_reg      <= res_found_reg;
            slot_step_reg  <= res_step_reg;
            used_count_reg <= 4'(count_reg);
        end
    end

    // Control and directory state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            seq_reg       <= '0;
            ring_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_reg    <= '0;
                cmp_vld_reg <= 1'b0;
                have_reg    <= 1'b0;
            end
            if (cmd.scan)
            begin
                scan_reg    <= scan_reg + IDX_ONE;
                cmp_vld_reg <= 1'b1;
            end
            else if (!cmd.capture)
            begin
                cmp_vld_reg <= 1'b0;
            end
            if (cmp_vld_reg && cand)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                valid_reg <= '0;
                seq_reg   <= '0;
                ring_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.save_wr)
            begin
                valid_reg[save_idx] <= 1'b1;
                seq_reg             <= seq_inc;
                if (seq_reg == 32'd0 || ring_inc >= SLOTS_X || ring_reg == '0)
                begin
                    ring_reg <= IDX_ONE;
                end
                else
                begin
                    ring_reg <= ring_inc[IDXW-1:0];
                end
                if (count_reg < SLOTS_C)
                begin
                    count_reg <= count_reg + CNTW'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = slot_index_reg;
    assign found      = found_reg;
    assign slot_step  = slot_step_reg;
    assign used_count = used_count_reg;

endmodule

/* src/checkpoint_slot_directory_core.sv */
// ----------------------------------------------------------------------------
// Checkpoint slot directory core
// Directory of checkpoint slots: an anchor slot plus a rotating ring.
// ----------------------------------------------------------------------------
// Usage: an input word carries opcode, step and slot and is taken when
// in_valid is high and in_stall is low. Each word yields one result word
// (slot_index, found, slot_step, used_count), taken when out_valid is high
// and out_stall is low.
// One operation is worked on at a time; in_stall stays high until its
// result has been loaded into the output register. Clear passes through
// S_CLEAR, save through S_SAVE_RD and S_SAVE_WR, query through S_QUERY_RD
// and S_QUERY_EV, find through S_FIND, S_FIND_END and S_FIND_RES; each then
// waits in S_RESP. Find reads the slot memory one entry per cycle, which
// sets its length; save and query each need one registered memory read.
// A result waiting in the output register does not block the next word
// from being taken; the following result waits until the first is taken.
// Reset clears the valid bits, the sequence counter, ring pointer and use
// count; slot memory contents are not cleared and are ignored until the
// slot is written. A stalled result holds its value on the output ports.
// ----------------------------------------------------------------------------
module checkpoint_slot_directory_core
    import cpsd_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] step,
    input  logic [2:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  slot_index,
    output logic        found,
    output logic [31:0] slot_step,
    output logic [3:0]  used_count
);

    cmd_t    cmd;
    status_t status;

    cpsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op_t'(opcode)),
        .status   (status),
        .cmd      (cmd)
    );

    cpsd_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .step       (step),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_index (slot_index),
        .found      (found),
        .slot_step  (slot_step),
        .used_count (used_count)
    );

endmodule
